>>> rtl/i2cm_pkg.sv
// Package for the I2C master byte engine: command codes, configuration register
// indexes, and the classified item and queue status types.
// No dependencies.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int CMD_BITS       = 3;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam int IN_DATA_BITS   = 16;
    localparam int OUT_DATA_BITS  = 16;

    localparam logic [CMD_BITS-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_START = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 3'd4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_PERIOD  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_ON_NACK = 8'd1;

    localparam logic [15:0] HALF_PERIOD_RESET  = 16'd500;
    localparam logic        STOP_ON_NACK_RESET = 1'b1;
    localparam logic [3:0]  BITS_PER_BYTE      = 4'd8;

    typedef struct packed {
        logic [CMD_BITS-1:0] kind;
        logic [7:0]          data_byte;
        logic                ack_to_send;
        logic                sda_level;
    } item_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

>>> rtl/i2cm_front.sv
// Input stage of the I2C master byte engine: accepts stream transactions,
// classifies the command and forwards the item to the queue.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front
    import i2cm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_DATA_BITS-1:0] s_axis_tdata,
    input  q_status_t               q_status,
    output logic                    push,
    output item_t                   push_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;
    logic [CMD_BITS-1:0] raw_cmd;

    assign raw_cmd       = s_axis_tdata[2:0];
    assign push          = valid_reg && !q_status.full;
    assign s_axis_tready = !valid_reg || !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_item     = item_reg;

    always_comb
    begin
        item_next  = item_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            case (raw_cmd)
                CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: item_next.kind = raw_cmd;
                default: item_next.kind = CMD_NONE;
            endcase
            item_next.data_byte   = s_axis_tdata[10:3];
            item_next.ack_to_send = s_axis_tdata[11];
            item_next.sda_level   = s_axis_tdata[12];
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

>>> rtl/i2cm_queue.sv
// Short register queue between the front and back parts of the I2C master
// byte engine. Depends on i2cm_pkg for the status type.
`timescale 1ns / 1ps

module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int WIDTH = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_status_t        status
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign pop_data         = slot_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == FULL_CNT);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.not_empty)
        else $error("Queue read while empty.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("Queue count beyond depth.");

endmodule

>>> rtl/i2cm_back.sv
// Execution part of the I2C master byte engine: configuration registers, the
// phase sequencer for the bus lines and the output register.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_back
    import i2cm_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  q_status_t                 q_status,
    input  item_t                     q_item,
    output logic                      pop,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata
);

    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_START_A   = 4'd1;
    localparam logic [3:0] PH_START_B   = 4'd2;
    localparam logic [3:0] PH_STOP_A    = 4'd3;
    localparam logic [3:0] PH_STOP_B    = 4'd4;
    localparam logic [3:0] PH_WR_LOW    = 4'd5;
    localparam logic [3:0] PH_WR_HIGH   = 4'd6;
    localparam logic [3:0] PH_WACK_LOW  = 4'd7;
    localparam logic [3:0] PH_WACK_HIGH = 4'd8;
    localparam logic [3:0] PH_RD_LOW    = 4'd9;
    localparam logic [3:0] PH_RD_HIGH   = 4'd10;
    localparam logic [3:0] PH_RACK_LOW  = 4'd11;
    localparam logic [3:0] PH_RACK_HIGH = 4'd12;

    function automatic logic [TIMER_BITS-1:0] clamp_half(input logic [15:0] h);
        logic [CW-1:0] h_ext;
        logic [CW-1:0] lim_ext;
        h_ext   = CW'(h);
        lim_ext = CW'({TIMER_BITS{1'b1}});
        if (h == 16'd0)
        begin
            clamp_half = TIMER_BITS'(1);
        end
        else if (h_ext > lim_ext)
        begin
            clamp_half = {TIMER_BITS{1'b1}};
        end
        else
        begin
            clamp_half = TIMER_BITS'(h_ext);
        end
    endfunction

    logic [TIMER_BITS-1:0] half_reg;
    logic                  stop_on_nack_reg;

    logic [3:0]            phase_reg,   phase_next;
    logic [TIMER_BITS-1:0] timer_reg,   timer_next;
    logic [3:0]            bits_reg,    bits_next;
    logic [7:0]            shift_reg,   shift_next;
    logic [7:0]            rx_reg,      rx_next;
    logic                  nack_reg,    nack_next;
    logic                  scl_reg,     scl_next;
    logic                  sda_reg,     sda_next;
    logic                  reply_reg,   reply_next;
    logic                  abort_reg,   abort_next;
    logic                  auto_reg,    auto_next;
    logic                  done_w;
    logic                  rejected_w;

    logic [TIMER_BITS-1:0] timer_inc;
    logic [3:0]            bits_inc;

    logic                     out_valid_reg, out_valid_next;
    logic [OUT_DATA_BITS-1:0] out_data_reg,  out_data_next;

    assign pop           = q_status.not_empty && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign timer_inc     = timer_reg + 1'b1;
    assign bits_inc      = bits_reg + 4'd1;

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        nack_next  = nack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        reply_next = reply_reg;
        abort_next = abort_reg;
        auto_next  = auto_reg;
        done_w     = 1'b0;
        rejected_w = 1'b0;
        if (phase_reg != PH_IDLE)
        begin
            rejected_w = (q_item.kind != CMD_NONE);
            timer_next = timer_inc;
            if (timer_inc >= half_reg)
            begin
                timer_next = '0;
                case (phase_reg)
                    PH_START_A:
                    begin
                        sda_next   = 1'b0;
                        phase_next = PH_START_B;
                    end
                    PH_START_B:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done_w     = 1'b1;
                    end
                    PH_STOP_A:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_STOP_B;
                    end
                    PH_STOP_B:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        done_w     = 1'b1;
                        if (auto_reg)
                        begin
                            abort_next = 1'b1;
                            auto_next  = 1'b0;
                        end
                    end
                    PH_WR_LOW, PH_WACK_LOW, PH_RD_LOW, PH_RACK_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = phase_reg + 4'd1;
                    end
                    PH_WR_HIGH:
                    begin
                        scl_next  = 1'b0;
                        bits_next = bits_inc;
                        if (bits_inc < BITS_PER_BYTE)
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            sda_next   = shift_reg[6];
                            phase_next = PH_WR_LOW;
                        end
                        else
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_WACK_LOW;
                        end
                    end
                    PH_WACK_HIGH:
                    begin
                        nack_next = q_item.sda_level;
                        scl_next  = 1'b0;
                        if (q_item.sda_level && stop_on_nack_reg)
                        begin
                            auto_next  = 1'b1;
                            sda_next   = 1'b0;
                            phase_next = PH_STOP_A;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done_w     = 1'b1;
                        end
                    end
                    PH_RD_HIGH:
                    begin
                        shift_next = {shift_reg[6:0], q_item.sda_level};
                        scl_next   = 1'b0;
                        bits_next  = bits_inc;
                        if (bits_inc < BITS_PER_BYTE)
                        begin
                            phase_next = PH_RD_LOW;
                        end
                        else
                        begin
                            rx_next    = {shift_reg[6:0], q_item.sda_level};
                            sda_next   = reply_reg;
                            phase_next = PH_RACK_LOW;
                        end
                    end
                    PH_RACK_HIGH:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done_w     = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else if (q_item.kind != CMD_NONE)
        begin
            timer_next = '0;
            bits_next  = '0;
            case (q_item.kind)
                CMD_START:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_START_A;
                end
                CMD_STOP:
                begin
                    auto_next  = 1'b0;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_STOP_A;
                end
                CMD_WRITE:
                begin
                    abort_next = 1'b0;
                    auto_next  = 1'b0;
                    shift_next = q_item.data_byte;
                    scl_next   = 1'b0;
                    sda_next   = q_item.data_byte[7];
                    phase_next = PH_WR_LOW;
                end
                default:
                begin
                    shift_next = '0;
                    reply_next = q_item.ack_to_send;
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                    phase_next = PH_RD_LOW;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, rejected_w, abort_next, nack_next, rx_next,
                              done_w, (phase_next != PH_IDLE), sda_next, scl_next};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg         <= clamp_half(HALF_PERIOD_RESET);
            stop_on_nack_reg <= STOP_ON_NACK_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_HALF_PERIOD)
            begin
                half_reg <= clamp_half(cfg_data);
            end
            else if (cfg_index == CFG_STOP_ON_NACK)
            begin
                stop_on_nack_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bits_reg      <= '0;
            shift_reg     <= '0;
            rx_reg        <= '0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            reply_reg     <= 1'b0;
            abort_reg     <= 1'b0;
            auto_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                timer_reg <= timer_next;
                bits_reg  <= bits_next;
                shift_reg <= shift_next;
                rx_reg    <= rx_next;
                nack_reg  <= nack_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                reply_reg <= reply_next;
                abort_reg <= abort_next;
                auto_reg  <= auto_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[3]) |-> !out_data_reg[2])
        else $error("Completion reported while still busy.");

    a_bit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= BITS_PER_BYTE)
        else $error("Bit counter ran past one byte.");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && rejected_w) |-> (phase_reg != PH_IDLE))
        else $error("Command rejected while idle.");

    a_idle_timer_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && phase_reg == PH_IDLE && q_item.kind == CMD_NONE) |=> $stable(timer_reg))
        else $error("Timer moved while idle.");

endmodule

>>> rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: input stage, item queue and
// execution part. Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   s_axis_tdata, one tick item
//   m_axis    out        m_axis_tvalid/m_axis_tready   m_axis_tdata, one tick result
//   cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One result per input item; one item per cycle is sustained while m_axis is not
// stalled, as the phase sequencer in the execution part takes an item on every pop.
// An item passes the input register, a queue slot and the output register in turn.
// The four-entry queue and the output register let either side stall on its own.
// Reset is asynchronous and active low; configuration writes are always accepted.
`timescale 1ns / 1ps

module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // cmd[2:0], data_byte[10:3], ack_to_send[11], sda_level[12], zero[15:13]
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // scl_level[0], sda_release[1], busy_res[2], done_res[3], rx_byte[11:4],
    // nack_seen[12], aborted[13], cmd_rejected[14], zero[15]
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int QUEUE_DEPTH = 4;

    q_status_t q_status;
    logic      push;
    item_t     push_item;
    logic      pop;
    item_t     pop_item;

    assign cfg_ready = 1'b1;

    i2cm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_status      (q_status),
        .push          (push),
        .push_item     (push_item)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(item_t))
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .pop       (pop),
        .pop_data  (pop_item),
        .status    (q_status)
    );

    i2cm_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_status      (q_status),
        .q_item        (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
